### rtl/bstack_pkg.sv
// Shared widths, operation codes and status codes for the bounded stack.
package bstack_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;

  // read_data, found_index, count, is_full, is_empty, padded to whole bytes
  localparam int OUT_DATA_W = 48;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

### rtl/bstack_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bstack_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bounded_stack_with_search.sv
// Top level: bounded LIFO stack of 32-bit words with top-down search.
//
// One operation per input item (push, pop, peek, clear, search); every item
// gives exactly one result carrying status, data and the fill level with full
// and empty flags. Entries live in a single-port-read RAM and a small
// sequencer drives it: push and clear pass through EXEC and DONE, a pop or
// peek that finds data also through RDWAIT (one RAM read with registered
// data), and search through SEARCH, comparing one entry per cycle through
// the one read port and the one comparator, stopping at the topmost match. The
// input is not ready while an item is in work; a finished result sits in the
// output register so the next item can be taken before it is drained. The
// capacity register may be written at any time the block is idle (cfg_ready
// is always high); values above DEPTH act as DEPTH. Entries are not cleared
// at reset; only entries below the fill level are ever read.
module bounded_stack_with_search #(
  parameter int DEPTH = bstack_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // tdata: value[31:0]
  input  logic [bstack_pkg::VALUE_W-1:0]       s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [bstack_pkg::KIND_W-1:0]        s_axis_tuser,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: read_data[31:0], found_index[37:32], count[44:38],
  //        is_full[45], is_empty[46], zero[47]
  output logic [bstack_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: status[1:0]
  output logic [bstack_pkg::STATUS_W-1:0]      m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bstack_pkg::CAP_W-1:0]         cfg_data
);
  import bstack_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int LW = (FW > CAP_W) ? FW : CAP_W;

  typedef enum logic [2:0] {IDLE, EXEC, RDWAIT, SEARCH, DONE} state_t;

  state_t               state;
  logic [CAP_W-1:0]     capacity;
  logic [FW-1:0]        fill;
  logic [KIND_W-1:0]    item_kind;
  logic [VALUE_W-1:0]   item_value;
  logic [STATUS_W-1:0]  res_status;
  logic [VALUE_W-1:0]   res_data;
  logic [AW-1:0]        res_index;
  logic [AW-1:0]        ptr;
  logic [FW-1:0]        scan;
  logic                 rd_pend;
  logic [AW-1:0]        rd_idx;

  logic [STATUS_W-1:0]  out_status;
  logic [VALUE_W-1:0]   out_data;
  logic [INDEX_W-1:0]   out_index;
  logic [COUNT_W-1:0]   out_count;
  logic                 out_full;
  logic                 out_empty;
  logic                 out_valid;

  logic [LW-1:0]        cap_ext;
  logic [LW-1:0]        lim;
  logic                 full_now;
  logic                 empty_now;
  logic                 out_free;
  logic                 key_hit;

  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [VALUE_W-1:0]   ram_rdata;

  assign cap_ext   = LW'(capacity);
  assign lim       = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
  assign full_now  = LW'(fill) >= lim;
  assign empty_now = (fill == '0);
  assign out_free  = !out_valid || m_axis_tready;
  assign key_hit   = rd_pend && (ram_rdata == item_value);

  assign s_axis_tready = (state == IDLE);
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {1'b0, out_empty, out_full, out_count, out_index, out_data};

  // RAM port control
  always_comb begin
    ram_we    = (state == EXEC) && (item_kind == KIND_PUSH) && !full_now;
    ram_re    = 1'b0;
    ram_raddr = ptr;
    if (state == EXEC && (item_kind == KIND_POP || item_kind == KIND_PEEK)) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(fill - FW'(1));
    end else if (state == SEARCH && !key_hit && scan != '0) begin
      ram_re    = 1'b1;
      ram_raddr = ptr;
    end
  end

  bstack_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(fill)),
    .wdata (item_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      capacity  <= CAP_RESET;
      fill      <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      // DONE reloads the output register itself
      if (out_valid && m_axis_tready && state != DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            item_kind  <= s_axis_tuser;
            item_value <= s_axis_tdata;
            state      <= EXEC;
          end
        end

        EXEC: begin
          res_data  <= '0;
          res_index <= '0;
          case (item_kind)
            KIND_PUSH: begin
              state <= DONE;
              if (full_now) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_OK;
                fill       <= fill + FW'(1);
              end
            end
            KIND_POP, KIND_PEEK: begin
              if (empty_now) begin
                res_status <= ST_EMPTY;
                state      <= DONE;
              end else begin
                res_status <= ST_OK;
                state      <= RDWAIT;
              end
            end
            KIND_CLEAR: begin
              res_status <= ST_OK;
              fill       <= '0;
              state      <= DONE;
            end
            KIND_SEARCH: begin
              res_status <= ST_OK;
              ptr        <= AW'(fill - FW'(1));
              scan       <= fill;
              rd_pend    <= 1'b0;
              state      <= SEARCH;
            end
            default: begin
              res_status <= ST_OK;
              state      <= DONE;
            end
          endcase
        end

        RDWAIT: begin
          res_data <= ram_rdata;
          if (item_kind == KIND_POP) begin
            fill <= fill - FW'(1);
          end
          state <= DONE;
        end

        SEARCH: begin
          // one compare per cycle against the word read the cycle before
          if (key_hit) begin
            res_index <= rd_idx;
            rd_pend   <= 1'b0;
            state     <= DONE;
          end else if (scan == '0) begin
            res_status <= ST_NOTFOUND;
            rd_pend    <= 1'b0;
            state      <= DONE;
          end else begin
            rd_pend <= 1'b1;
            rd_idx  <= ptr;
            ptr     <= ptr - AW'(1);
            scan    <= scan - FW'(1);
          end
        end

        DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_data   <= res_data;
            out_index  <= INDEX_W'(res_index);
            out_count  <= COUNT_W'(fill);
            out_full   <= full_now;
            out_empty  <= empty_now;
            state      <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("fill level above depth");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again while an item is in work");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_FULL |-> out_full)
    else $error("push rejected as full without full flag");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> out_empty && out_data == '0)
    else $error("empty reject with data or without empty flag");

  a_count_load: assert property (@(posedge clk) disable iff (rst)
    state == DONE && out_free |=> out_valid && out_count == COUNT_W'(fill))
    else $error("result count differs from fill level");

endmodule

### tb/tb_top.sv
// Testbench for bounded_stack_with_search: stream driver, result checker, stack predictor.
module tb_top;
  import bstack_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int IDLE_PCT = 34;
  localparam int WATCHDOG_LIMIT = 1000;

  // kinds the block decodes as no-ops
  localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               drain;  // hold until every reply has come back
  } stack_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_data;
    logic [INDEX_W-1:0]  found_index;
    logic [COUNT_W-1:0]  count;
    logic                is_full;
    logic                is_empty;
  } stack_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic [VALUE_W-1:0]    s_axis_tdata = '0;
  logic [KIND_W-1:0]     s_axis_tuser = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_data = '0;

  // predictor state
  logic [VALUE_W-1:0] words [0:DEPTH-1];
  int                 level = 0;
  logic [CAP_W-1:0]   cap_q = CAP_RESET;

  stack_op_t    ops_waiting [$];
  stack_reply_t replies_due [$];
  stack_op_t    cur_op;

  int taken_seen = 0;
  bit no_idle = 1'b0;
  int errors = 0;
  int items_in = 0;
  int replies_checked = 0;
  int cap_writes = 0;
  int quiet = 0;
  int kind_seen [0:7];
  int status_seen [0:3];

  bounded_stack_with_search #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the model stack and return the reply it gives.
  function automatic stack_reply_t stack_op(input logic [KIND_W-1:0] k,
                                            input logic [VALUE_W-1:0] v);
    stack_reply_t r;
    int lim;
    int i;
    bit hit;
    r = '0;
    hit = 1'b0;
    lim = (int'(cap_q) > DEPTH) ? DEPTH : int'(cap_q);
    case (k)
      KIND_PUSH: begin
        if (level >= lim) r.status = ST_FULL;
        else begin
          words[level] = v;
          level++;
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (level == 0) r.status = ST_EMPTY;
        else begin
          r.read_data = words[level-1];
          if (k == KIND_POP) level--;
        end
      end
      KIND_CLEAR: level = 0;
      KIND_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (i = level - 1; i >= 0 && !hit; i--) begin
          if (words[i] == v) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.found_index = INDEX_W'(i);
          end
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(level);
    r.is_full = (level >= lim);
    r.is_empty = (level == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("tb_top: reply %0d: %s", replies_checked, msg);
  endtask

  // Input driver: holds an item until taken, idles at random between items.
  always @(negedge clk) begin : drive_ops
    logic go;
    go = s_axis_tvalid && (items_in == taken_seen);
    taken_seen = items_in;
    if (!rst && !go && ops_waiting.size() != 0
        && (no_idle || $urandom_range(99) >= IDLE_PCT)
        && (!ops_waiting[0].drain || replies_due.size() == 0)) begin
      cur_op = ops_waiting.pop_front();
      s_axis_tdata <= cur_op.value;
      s_axis_tuser <= cur_op.kind;
      go = 1'b1;
    end
    s_axis_tvalid <= go;
    m_axis_tready <= !rst && (no_idle || $urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: checks replies, predicts accepted items, tracks capacity, watchdog.
  always @(posedge clk) begin : watch_bus
    stack_reply_t got;
    stack_reply_t want;
    bit fired;
    fired = 1'b0;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      fired = 1'b1;
      got.status      = m_axis_tuser;
      got.read_data   = m_axis_tdata[31:0];
      got.found_index = m_axis_tdata[37:32];
      got.count       = m_axis_tdata[44:38];
      got.is_full     = m_axis_tdata[45];
      got.is_empty    = m_axis_tdata[46];
      status_seen[got.status]++;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("reply with none expected (status %0d)", got.status));
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %0h, want %0h", got.read_data,
                                    want.read_data));
        if (got.found_index !== want.found_index)
          report_mismatch($sformatf("found_index %0d, want %0d", got.found_index,
                                    want.found_index));
        if (got.count !== want.count)
          report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
        if (got.is_full !== want.is_full)
          report_mismatch($sformatf("is_full %b, want %b", got.is_full, want.is_full));
        if (got.is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty %b, want %b", got.is_empty, want.is_empty));
      end
      replies_checked++;
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      fired = 1'b1;
      replies_due.push_back(stack_op(s_axis_tuser, s_axis_tdata));
      kind_seen[s_axis_tuser]++;
      items_in++;
    end
    if (!rst && cfg_valid && cfg_ready) begin
      fired = 1'b1;
      cap_q = cfg_data;
      cap_writes++;
    end
    if (rst || fired) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_top: timeout with %0d replies outstanding", replies_due.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic queue_op(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
                          input bit drain = 1'b0);
    stack_op_t op;
    op.kind = k;
    op.value = v;
    op.drain = drain;
    ops_waiting.push_back(op);
  endtask

  // Wait until the block is idle: nothing queued, nothing in flight.
  task automatic settle();
    do @(posedge clk);
    while (ops_waiting.size() != 0 || s_axis_tvalid || replies_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] cap);
    int seen;
    seen = cap_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(negedge clk);
    while (cap_writes == seen);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random operations; keys are mostly drawn from a small pool so searches hit.
  task automatic random_ops(input int n, input int push_pct);
    logic [VALUE_W-1:0] pool [0:5];
    logic [KIND_W-1:0] k;
    logic [VALUE_W-1:0] v;
    int j;
    int r;
    for (j = 0; j < 6; j++) pool[j] = $urandom;
    for (j = 0; j < n; j++) begin
      r = $urandom_range(99);
      if (r < push_pct) k = KIND_PUSH;
      else begin
        r = $urandom_range(99);
        if (r < 35) k = KIND_POP;
        else if (r < 55) k = KIND_PEEK;
        else if (r < 93) k = KIND_SEARCH;
        else if (r < 97) k = KIND_CLEAR;
        else k = KIND_W'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
      end
      v = ($urandom_range(99) < 60) ? pool[$urandom_range(5)] : VALUE_W'($urandom);
      queue_op(k, v, $urandom_range(99) < 2);
    end
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n, input int push_pct);
    settle();
    write_cap(cap);
    random_ops(n, push_pct);
  endtask

  initial begin : stimulus
    int j;
    for (j = 0; j < 8; j++) kind_seen[j] = 0;
    for (j = 0; j < 4; j++) status_seen[j] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty stack: pop, peek and search all refused; no-op kind
    queue_op(KIND_POP, 32'h0);
    queue_op(KIND_PEEK, 32'hFFFF_FFFF);
    queue_op(KIND_SEARCH, 32'h7);
    queue_op(KIND_UNUSED_LAST, 32'h5A5A_A5A5);
    // extreme words, duplicate zero so search must pick the upper copy
    queue_op(KIND_PUSH, 32'h7FFF_FFFF);
    queue_op(KIND_PUSH, 32'h8000_0000);
    queue_op(KIND_PUSH, 32'h0);
    queue_op(KIND_PUSH, 32'hFFFF_FFFF);
    queue_op(KIND_PUSH, 32'h0, 1'b1);
    queue_op(KIND_SEARCH, 32'h0);
    queue_op(KIND_SEARCH, 32'h7FFF_FFFF);
    queue_op(KIND_PEEK, 32'h0);
    queue_op(KIND_POP, 32'h0);
    queue_op(KIND_UNUSED_FIRST, 32'hFFFF_FFFF);
    queue_op(KIND_CLEAR, 32'h0);
    queue_op(KIND_POP, 32'h0);
    queue_op(KIND_UNUSED_FIRST + 3'd1, 32'h0);
    settle();

    // zero capacity: full and empty at once, every push refused
    write_cap(7'd0);
    queue_op(KIND_PUSH, 32'h1234_5678);
    queue_op(KIND_SEARCH, 32'h1234_5678);
    settle();

    // capacity two, then lowered below the fill level
    write_cap(7'd2);
    queue_op(KIND_PUSH, 32'hAAAA_AAAA);
    queue_op(KIND_PUSH, 32'h5555_5555);
    queue_op(KIND_PUSH, 32'h1);
    settle();
    write_cap(7'd1);
    queue_op(KIND_PUSH, 32'h2);
    queue_op(KIND_POP, 32'h0);
    queue_op(KIND_POP, 32'h0);
    queue_op(KIND_PUSH, 32'h3);
    queue_op(KIND_PUSH, 32'h4);
    queue_op(KIND_CLEAR, 32'h0, 1'b1);

    // random part; the first phase runs with no idling on either side
    settle();
    no_idle = 1'b1;
    run_phase(7'd64, 60, 45);
    settle();
    no_idle = 1'b0;
    run_phase(7'd5, 50, 45);
    run_phase(7'd127, 100, 90);  // above depth: fills to the built depth
    run_phase(7'd1, 40, 40);
    run_phase(7'd17, 60, 50);
    run_phase(7'd0, 25, 50);
    run_phase(CAP_RESET, 60, 45);
    settle();
    repeat (20) @(posedge clk);

    $display("tb_top: %0d items, %0d replies checked, %0d capacity writes (0 to 127)",
             items_in, replies_checked, cap_writes);
    $display("tb_top: push %0d pop %0d peek %0d clear %0d search %0d no-op %0d; %s %0d %0d %0d",
             kind_seen[KIND_PUSH], kind_seen[KIND_POP], kind_seen[KIND_PEEK],
             kind_seen[KIND_CLEAR], kind_seen[KIND_SEARCH],
             kind_seen[5] + kind_seen[6] + kind_seen[7], "full/empty/miss replies",
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_NOTFOUND]);
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
